// ===== sv/ttg_pkg.sv =====
`timescale 1ns / 1ps
package ttg_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DLOAD,
    ST_DRUN,
    ST_EMIT
  } ttg_state_e;

  // Word slots of one held vertex
  localparam int unsigned WordsPerVert = 8;
  localparam logic [2:0] W_PX = 3'd0;
  localparam logic [2:0] W_PY = 3'd1;
  localparam logic [2:0] W_PZ = 3'd2;
  localparam logic [2:0] W_NX = 3'd3;
  localparam logic [2:0] W_NY = 3'd4;
  localparam logic [2:0] W_NZ = 3'd5;
  localparam logic [2:0] W_U  = 3'd6;
  localparam logic [2:0] W_V  = 3'd7;

  // Datapath widths: operand, product, difference of products, quotient
  localparam int unsigned OpW  = 33;
  localparam int unsigned PrdW = 66;
  localparam int unsigned SumW = 67;
  localparam int unsigned QW   = 33;

  // Multiplier steps: two for the determinant, two per tangent numerator
  localparam logic [3:0] MulLast = 4'd8;

  typedef logic [31:0] word_t;

endpackage

// ===== sv/triangle_tangent_generator.sv =====
`timescale 1ns / 1ps
// After the third vertex of a triangle is taken, the block runs the multiply steps, three divides
// and a store of the last tangent component before it offers the first output word.
// The first two vertices are only held and give no output.
// No new vertex is taken until the triangle is emitted; the work is set by one shared
// 33x33 multiplier (8 products) and a one-bit-per-cycle restoring divider run three times.
// Reset: rst_ni clears the sequencer and the vertex count; held vertex words are not cleared.
module triangle_tangent_generator
  import ttg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] norm_x_i,
  input  logic signed [31:0] norm_y_i,
  input  logic signed [31:0] norm_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_raw_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [31:0] out_norm_x_o,
  output logic signed [31:0] out_norm_y_o,
  output logic signed [31:0] out_norm_z_o,
  output logic signed [31:0] out_u_o,
  output logic signed [31:0] out_v_flipped_o,
  output logic signed [31:0] tangent_x_o,
  output logic signed [31:0] tangent_y_o,
  output logic signed [31:0] tangent_z_o,
  output logic               last_of_triangle_o
);

  localparam int unsigned NW = SumW + FRAC_BITS;
  localparam int unsigned RW = SumW + 1;

  ttg_state_e state_q, state_d;

  logic [1:0] vcnt_q;
  word_t      hv_q  [2][WordsPerVert];
  word_t      cur_q [WordsPerVert];

  logic [3:0]               mstep_q;
  logic signed [PrdW-1:0]   prod_q;
  logic signed [PrdW-1:0]   acc_q;
  logic signed [SumW-1:0]   res_q [4];

  logic [1:0]        dc_q;
  logic [5:0]        dcnt_q;
  logic [RW-1:0]     rem_q;
  logic [QW-1:0]     nlo_q;
  logic [QW-1:0]     quo_q;
  logic              ovf_q;
  word_t             tan_q [3];
  logic [1:0]        ecnt_q;
  logic              wr_pend_q;
  logic [1:0]        wr_c_q;

  logic              in_acc, out_acc;
  logic signed [33:0] vflip_full;
  word_t             vflip;
  word_t             in_w [WordsPerVert];

  // Flip v and saturate
  always_comb begin
    vflip_full = (34'sd1 <<< FRAC_BITS) - 34'(tex_v_raw_i);
    if (vflip_full > 34'sd2147483647) begin
      vflip = 32'h7FFF_FFFF;
    end else if (vflip_full < -34'sd2147483648) begin
      vflip = 32'h8000_0000;
    end else begin
      vflip = vflip_full[31:0];
    end
    in_w[W_PX] = pos_x_i;
    in_w[W_PY] = pos_y_i;
    in_w[W_PZ] = pos_z_i;
    in_w[W_NX] = norm_x_i;
    in_w[W_NY] = norm_y_i;
    in_w[W_NZ] = norm_z_i;
    in_w[W_U]  = tex_u_i;
    in_w[W_V]  = vflip;
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Pick the operands of the shared multiplier
  logic signed [OpW-1:0] du1, dv1, du2, dv2, opa, opb;
  logic signed [OpW-1:0] e1 [3];
  logic signed [OpW-1:0] e2 [3];

  always_comb begin
    du1 = OpW'($signed(hv_q[1][W_U])) - OpW'($signed(hv_q[0][W_U]));
    dv1 = OpW'($signed(hv_q[1][W_V])) - OpW'($signed(hv_q[0][W_V]));
    du2 = OpW'($signed(cur_q[W_U]))   - OpW'($signed(hv_q[0][W_U]));
    dv2 = OpW'($signed(cur_q[W_V]))   - OpW'($signed(hv_q[0][W_V]));
    for (int c = 0; c < 3; c++) begin
      e1[c] = OpW'($signed(hv_q[1][c])) - OpW'($signed(hv_q[0][c]));
      e2[c] = OpW'($signed(cur_q[c]))   - OpW'($signed(hv_q[0][c]));
    end
    unique case (mstep_q)
      4'd0:    begin opa = du1; opb = dv2;   end
      4'd1:    begin opa = du2; opb = dv1;   end
      4'd2:    begin opa = dv2; opb = e1[0]; end
      4'd3:    begin opa = dv1; opb = e2[0]; end
      4'd4:    begin opa = dv2; opb = e1[1]; end
      4'd5:    begin opa = dv1; opb = e2[1]; end
      4'd6:    begin opa = dv2; opb = e1[2]; end
      4'd7:    begin opa = dv1; opb = e2[2]; end
      default: begin opa = '0;  opb = '0;    end
    endcase
  end

  // Divider operands and one restoring step
  logic signed [SumW-1:0] nsel, det;
  logic [SumW-1:0]        nmag, dmag;
  logic [NW-1:0]          nsh;
  logic [RW-1:0]          rsh, rinit;
  logic                   rge;

  always_comb begin
    det   = res_q[0];
    nsel  = res_q[dc_q + 2'd1];
    nmag  = nsel[SumW-1] ? SumW'(-nsel) : SumW'(nsel);
    dmag  = det[SumW-1] ? SumW'(-det) : SumW'(det);
    nsh   = {nmag, {FRAC_BITS{1'b0}}};
    rinit = RW'(nsh[NW-1:QW]);
    rsh   = {rem_q[RW-2:0], nlo_q[QW-1]};
    rge   = rsh >= RW'(dmag);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && vcnt_q == 2'd2) state_d = ST_MUL;
      ST_MUL:   if (mstep_q == MulLast) state_d = ST_DLOAD;
      ST_DLOAD: state_d = ST_DRUN;
      ST_DRUN: begin
        if (dcnt_q == 6'(QW - 1)) state_d = (dc_q == 2'd2) ? ST_EMIT : ST_DLOAD;
      end
      ST_EMIT:  if (out_acc && ecnt_q == 2'd2) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs; hold valid until the last tangent component is stored
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT) && !wr_pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vcnt_q  <= 2'd0;
      mstep_q <= 4'd0;
      dc_q    <= 2'd0;
      dcnt_q  <= 6'd0;
      ecnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          mstep_q <= 4'd0;
          dc_q    <= 2'd0;
          ecnt_q  <= 2'd0;
          if (in_acc) vcnt_q <= (vcnt_q == 2'd2) ? 2'd0 : vcnt_q + 2'd1;
        end
        ST_MUL:   mstep_q <= mstep_q + 4'd1;
        ST_DLOAD: dcnt_q <= 6'd0;
        ST_DRUN: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(QW - 1)) dc_q <= dc_q + 2'd1;
        end
        ST_EMIT:  if (out_acc) ecnt_q <= ecnt_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      for (int j = 0; j < WordsPerVert; j++) begin
        if (vcnt_q == 2'd2) cur_q[j] <= in_w[j];
        else hv_q[vcnt_q[0]][j] <= in_w[j];
      end
    end
    // Multiply, then fold each pair of products into a difference
    if (state_q == ST_MUL) begin
      prod_q <= opa * opb;
      if (mstep_q != 4'd0) begin
        if (!mstep_q[0]) res_q[2'((mstep_q - 4'd1) >> 1)] <= SumW'(acc_q) - SumW'(prod_q);
        else acc_q <= prod_q;
      end
    end
    if (state_q == ST_DLOAD) begin
      rem_q <= rinit;
      nlo_q <= nsh[QW-1:0];
      quo_q <= '0;
      ovf_q <= rinit >= RW'(dmag);
    end
    // One quotient bit per cycle
    if (state_q == ST_DRUN) begin
      rem_q <= rge ? rsh - RW'(dmag) : rsh;
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[QW-2:0], rge};
    end
  end

  // Write the finished quotient in the cycle after the last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      wr_c_q    <= 2'd0;
    end else begin
      wr_pend_q <= (state_q == ST_DRUN && dcnt_q == 6'(QW - 1));
      wr_c_q    <= dc_q;
    end
  end

  logic signed [SumW-1:0] wn;
  logic [SumW-1:0]        wnmag;
  logic                   wneg;
  logic [QW-1:0]          wlim;
  word_t                  wout;
  always_comb begin
    wn    = res_q[wr_c_q + 2'd1];
    wnmag = wn[SumW-1] ? SumW'(-wn) : SumW'(wn);
    wneg  = (wn[SumW-1] != det[SumW-1]) && (quo_q != '0 || ovf_q);
    wlim  = wneg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
    if (dmag == '0 || wnmag == '0) begin
      wout = '0;
    end else if (ovf_q || quo_q > wlim) begin
      wout = wlim[31:0];
      if (wneg) wout = 32'h8000_0000;
    end else begin
      wout = wneg ? 32'(-quo_q) : quo_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) tan_q[wr_c_q] <= wout;
  end

  // Present the selected vertex with the tangent
  word_t ow [WordsPerVert];
  always_comb begin
    for (int j = 0; j < WordsPerVert; j++) begin
      unique case (ecnt_q)
        2'd0:    ow[j] = hv_q[0][j];
        2'd1:    ow[j] = hv_q[1][j];
        default: ow[j] = cur_q[j];
      endcase
    end
    out_pos_x_o        = ow[W_PX];
    out_pos_y_o        = ow[W_PY];
    out_pos_z_o        = ow[W_PZ];
    out_norm_x_o       = ow[W_NX];
    out_norm_y_o       = ow[W_NY];
    out_norm_z_o       = ow[W_NZ];
    out_u_o            = ow[W_U];
    out_v_flipped_o    = ow[W_V];
    tangent_x_o        = tan_q[0];
    tangent_y_o        = tan_q[1];
    tangent_z_o        = tan_q[2];
    last_of_triangle_o = (ecnt_q == 2'd2);
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q != 2'd3) else $error("vertex count out of range");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ecnt_q != 2'd3) else $error("emit index out of range");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q[0] == '0) |->
      (tangent_x_o == 32'sd0 && tangent_y_o == 32'sd0 && tangent_z_o == 32'sd0))
    else $error("degenerate triangle with nonzero tangent");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> in_stall_o) else $error("input taken while computing");

endmodule
